### design/eemi_pkg.sv
`default_nettype none
// ============================================================================
// eemi_pkg - shared definitions for the extended Euclid modular inverse
// Field widths, the default operand width and the sequencer state type.
// ============================================================================
package eemi_pkg;

    // Widths of the result fields, fixed by the interface.
    localparam int WORD_W  = 32;
    localparam int COEFF_W = 34;

    // Default internal operand width.
    localparam int OPERAND_WIDTH_DEFAULT = 32;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_UPD   = 6'b001000,
        ST_RED   = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

endpackage : eemi_pkg
`default_nettype wire

### design/eemi_step_unit.sv
`default_nettype none
// ============================================================================
// eemi_step_unit - one restoring division step with coefficient accumulation
// Produces one quotient bit per cycle, MSB first, and folds it into the two
// running products q*x1 and q*y1 by Horner's rule.
// ============================================================================
module eemi_step_unit #(
    parameter int OPERAND_WIDTH = eemi_pkg::OPERAND_WIDTH_DEFAULT
) (
    input  wire logic [OPERAND_WIDTH-1:0] rem,
    input  wire logic                     dvd_msb,
    input  wire logic [OPERAND_WIDTH-1:0] divisor,
    input  wire logic [OPERAND_WIDTH-1:0] acc_x,
    input  wire logic [OPERAND_WIDTH-1:0] acc_y,
    input  wire logic [OPERAND_WIDTH-1:0] coef_x,
    input  wire logic [OPERAND_WIDTH-1:0] coef_y,
    output logic      [OPERAND_WIDTH-1:0] rem_next,
    output logic      [OPERAND_WIDTH-1:0] acc_x_next,
    output logic      [OPERAND_WIDTH-1:0] acc_y_next
);
    import eemi_pkg::*;

    logic [OPERAND_WIDTH:0] trial;
    logic [OPERAND_WIDTH:0] diff;
    logic                   q_bit;

    always_comb
    begin
        trial = {rem, dvd_msb};
        diff  = trial - {1'b0, divisor};
        q_bit = (trial >= {1'b0, divisor});
        // The partial remainder always stays below the divisor, so it fits.
        rem_next   = q_bit ? diff[OPERAND_WIDTH-1:0] : trial[OPERAND_WIDTH-1:0];
        // Partial products never exceed the final coefficient, which fits.
        acc_x_next = {acc_x[OPERAND_WIDTH-2:0], 1'b0}
                     + (q_bit ? coef_x : {OPERAND_WIDTH{1'b0}});
        acc_y_next = {acc_y[OPERAND_WIDTH-2:0], 1'b0}
                     + (q_bit ? coef_y : {OPERAND_WIDTH{1'b0}});
    end

endmodule : eemi_step_unit
`default_nettype wire

### design/extended_euclid_modular_inverse.sv
`default_nettype none
// ============================================================================
// extended_euclid_modular_inverse - gcd, modular inverse and Bezout pair
// Iterative extended Euclidean algorithm built round one shared
// divide-and-accumulate step unit under a small one-hot sequencer.
// ============================================================================
//
//  Channel   Handshake        Payload
//  --------  ---------------  --------------------------------------------
//  input     start & !busy    value, modulus
//  result    done (1 cycle)   inverse, divisor, modulus_coeff, invertible
//
//  Each transaction runs N Euclid steps between acceptance and the result
//  strobe (N is zero when the modulus is zero, at most about 47 for 32-bit
//  operands). Each step tests for termination in ST_CHECK, develops one
//  quotient bit per cycle in ST_DIV through the step unit, then updates the
//  remainders and coefficients in ST_UPD; then ST_RED and ST_FIN finish.
//  busy stays high from acceptance until the result is presented; a new
//  transaction may be started in the very cycle that done is high.
//  Reset (rst_n, asynchronous) returns the sequencer to idle and clears the
//  strobe. The receiver cannot stall: done is high for one cycle only.
//
module extended_euclid_modular_inverse #(
    parameter int OPERAND_WIDTH = eemi_pkg::OPERAND_WIDTH_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [eemi_pkg::WORD_W-1:0]        value,
    input  wire logic [eemi_pkg::WORD_W-1:0]        modulus,
    output logic                                    done,
    output logic      [eemi_pkg::WORD_W-1:0]        inverse,
    output logic      [eemi_pkg::WORD_W-1:0]        divisor,
    output logic signed [eemi_pkg::COEFF_W-1:0]     modulus_coeff,
    output logic                                    invertible
);
    import eemi_pkg::*;

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(W);
    // Width at which the modulus coefficient is negated before truncation.
    localparam int NEG_W = (W > COEFF_W) ? W : COEFF_W;

    // Sequencer.
    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             odd_reg, odd_next;
    logic             done_reg, done_next;

    // Euclid state: remainders and coefficient magnitudes.
    logic [W-1:0] r0_reg, r0_next;
    logic [W-1:0] r1_reg, r1_next;
    logic [W-1:0] x0_reg, x0_next;
    logic [W-1:0] x1_reg, x1_next;
    logic [W-1:0] y0_reg, y0_next;
    logic [W-1:0] y1_reg, y1_next;
    logic [W-1:0] mod_reg, mod_next;

    // Division working registers.
    logic [W-1:0] dvd_reg, dvd_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] accx_reg, accx_next;
    logic [W-1:0] accy_reg, accy_next;
    logic [W-1:0] red_reg, red_next;

    // Result registers.
    logic [WORD_W-1:0]  inv_out_reg, inv_out_next;
    logic [WORD_W-1:0]  gcd_out_reg, gcd_out_next;
    logic [COEFF_W-1:0] coef_out_reg, coef_out_next;
    logic               invt_out_reg, invt_out_next;

    // Step unit outputs.
    logic [W-1:0] su_rem;
    logic [W-1:0] su_accx;
    logic [W-1:0] su_accy;

    // Normalisation helpers.
    logic [NEG_W-1:0] y_ext;
    logic [NEG_W-1:0] y_neg;
    logic [W-1:0]     inv_final;

    eemi_step_unit #(
        .OPERAND_WIDTH (W)
    ) u_step (
        .rem        (rem_reg),
        .dvd_msb    (dvd_reg[W-1]),
        .divisor    (r1_reg),
        .acc_x      (accx_reg),
        .acc_y      (accy_reg),
        .coef_x     (x1_reg),
        .coef_y     (y1_reg),
        .rem_next   (su_rem),
        .acc_x_next (su_accx),
        .acc_y_next (su_accy)
    );

    // The last x is at most modulus/gcd, so a single compare and subtract
    // reduces it; the odd-parity sign is applied in the following cycle.
    always_comb
    begin
        y_ext = NEG_W'(y0_reg);
        y_neg = -y_ext;
        if ((mod_reg != '0) && odd_reg && (red_reg != '0))
        begin
            inv_final = mod_reg - red_reg;
        end
        else
        begin
            inv_final = red_reg;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        odd_next      = odd_reg;
        done_next     = 1'b0;
        r0_next       = r0_reg;
        r1_next       = r1_reg;
        x0_next       = x0_reg;
        x1_next       = x1_reg;
        y0_next       = y0_reg;
        y1_next       = y1_reg;
        mod_next      = mod_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        accx_next     = accx_reg;
        accy_next     = accy_reg;
        red_next      = red_reg;
        inv_out_next  = inv_out_reg;
        gcd_out_next  = gcd_out_reg;
        coef_out_next = coef_out_reg;
        invt_out_next = invt_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    r0_next    = W'(value);
                    r1_next    = W'(modulus);
                    mod_next   = W'(modulus);
                    x0_next    = W'(1);
                    x1_next    = '0;
                    y0_next    = '0;
                    y1_next    = W'(1);
                    odd_next   = 1'b0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // Finished once the remainder reaches zero; otherwise set
                // up a fresh long division of r0 by r1.
                if (r1_reg == '0)
                begin
                    state_next = ST_RED;
                end
                else
                begin
                    dvd_next   = r0_reg;
                    rem_next   = '0;
                    accx_next  = '0;
                    accy_next  = '0;
                    cnt_next   = CNT_W'(W - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = su_rem;
                accx_next = su_accx;
                accy_next = su_accy;
                dvd_next  = {dvd_reg[W-2:0], 1'b0};
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                r0_next    = r1_reg;
                r1_next    = rem_reg;
                x0_next    = x1_reg;
                x1_next    = x0_reg + accx_reg;
                y0_next    = y1_reg;
                y1_next    = y0_reg + accy_reg;
                odd_next   = ~odd_reg;
                state_next = ST_CHECK;
            end
            ST_RED:
            begin
                if ((mod_reg != '0) && (x0_reg >= mod_reg))
                begin
                    red_next = x0_reg - mod_reg;
                end
                else
                begin
                    red_next = x0_reg;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                inv_out_next  = WORD_W'(inv_final);
                gcd_out_next  = WORD_W'(r0_reg);
                coef_out_next = (!odd_reg && (y0_reg != '0)) ? COEFF_W'(y_neg)
                                                             : COEFF_W'(y_ext);
                invt_out_next = (r0_reg == W'(1));
                done_next     = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        odd_reg      <= odd_next;
        r0_reg       <= r0_next;
        r1_reg       <= r1_next;
        x0_reg       <= x0_next;
        x1_reg       <= x1_next;
        y0_reg       <= y0_next;
        y1_reg       <= y1_next;
        mod_reg      <= mod_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        accx_reg     <= accx_next;
        accy_reg     <= accy_next;
        red_reg      <= red_next;
        inv_out_reg  <= inv_out_next;
        gcd_out_reg  <= gcd_out_next;
        coef_out_reg <= coef_out_next;
        invt_out_reg <= invt_out_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign inverse       = inv_out_reg;
    assign divisor       = gcd_out_reg;
    assign modulus_coeff = coef_out_reg;
    assign invertible    = invt_out_reg;

endmodule : extended_euclid_modular_inverse
`default_nettype wire
